@@ sv/base64_stream_encoder_assert.svh @@
// ----------------------------------------------------------------------------
// base64 stream encoder assertion macros
// shared property forms for the encoder checks
// ----------------------------------------------------------------------------
`ifndef BASE64_STREAM_ENCODER_ASSERT_SVH
`define BASE64_STREAM_ENCODER_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define B64_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("base64 encoder check failed");

// next-cycle implication, sampled on clk, off during reset
`define B64_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("base64 encoder check failed");

`endif

@@ sv/b64enc_pkg.sv @@
// ----------------------------------------------------------------------------
// b64enc_pkg
// types, constants and the character mapping of the base64 encoder
// ----------------------------------------------------------------------------
package b64enc_pkg;

  localparam logic [7:0] PAD_CHAR = 8'h3D;

  // one closed group as it travels from front to back
  typedef struct packed {
    logic [23:0] group;
    logic [1:0]  nbytes;
    logic        fin;
  } grp_entry_t;

  typedef struct packed {
    logic       valid;
    grp_entry_t entry;
  } grp_push_t;

  typedef struct packed {
    logic       valid;
    grp_entry_t entry;
  } grp_head_t;

  function automatic logic [7:0] sextet_char(input logic [5:0] idx);
    logic [7:0] c;
    if (idx < 6'd26) begin
      c = 8'h41 + {2'b00, idx};
    end else if (idx < 6'd52) begin
      c = 8'h61 + {2'b00, idx - 6'd26};
    end else if (idx < 6'd62) begin
      c = 8'h30 + {2'b00, idx - 6'd52};
    end else if (idx == 6'd62) begin
      c = 8'h2B;
    end else begin
      c = 8'h2F;
    end
    return c;
  endfunction

  function automatic logic [7:0] enc_char(input logic [23:0] group,
                                          input logic [1:0]  nbytes,
                                          input logic [1:0]  k);
    logic [5:0] idx;
    case (k)
      2'd0:    idx = group[23:18];
      2'd1:    idx = group[17:12];
      2'd2:    idx = group[11:6];
      default: idx = group[5:0];
    endcase
    return (k > nbytes) ? PAD_CHAR : sextet_char(idx);
  endfunction

endpackage

@@ sv/b64enc_in_if.sv @@
// ----------------------------------------------------------------------------
// b64enc_in_if
// byte channel into the encoder
// ----------------------------------------------------------------------------
interface b64enc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       final_byte;

  modport source (output valid, output data_byte, output final_byte, input ready);
  modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

@@ sv/b64enc_out_if.sv @@
// ----------------------------------------------------------------------------
// b64enc_out_if
// character channel out of the encoder
// ----------------------------------------------------------------------------
interface b64enc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       run_end;
  logic       message_end;

  modport source (output valid, output out_char, output run_end, output message_end,
                  input ready);
  modport sink   (input valid, input out_char, input run_end, input message_end,
                  output ready);
endinterface

@@ sv/b64enc_front.sv @@
// ----------------------------------------------------------------------------
// b64enc_front
// collects bytes into groups of three and hands closed groups to the queue
// ----------------------------------------------------------------------------
module b64enc_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            in_data_byte,
  input  logic                  in_final_byte,
  input  logic                  q_ready,
  output b64enc_pkg::grp_push_t push
);

  logic [15:0] pend_r, pend_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic [1:0]  cnt;
  logic        accept;
  logic        closes;

  assign in_ready = q_ready;
  assign accept   = in_valid && q_ready;
  assign cnt      = (cnt_r > 2'd2) ? 2'd2 : cnt_r;
  assign closes   = (cnt == 2'd2) || in_final_byte;

  always_comb begin
    pend_nxt          = pend_r;
    cnt_nxt           = cnt_r;
    push.valid        = accept && closes;
    push.entry.nbytes = cnt + 2'd1;
    push.entry.fin    = in_final_byte;
    case (cnt)
      2'd0:    push.entry.group = {in_data_byte, 16'h0000};
      2'd1:    push.entry.group = {pend_r[15:8], in_data_byte, 8'h00};
      default: push.entry.group = {pend_r, in_data_byte};
    endcase
    if (accept) begin
      if (closes) begin
        pend_nxt = 16'h0000;
        cnt_nxt  = 2'd0;
      end else begin
        if (cnt == 2'd0) begin
          pend_nxt = {in_data_byte, 8'h00};
        end else begin
          pend_nxt = {pend_r[15:8], in_data_byte};
        end
        cnt_nxt = cnt + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 16'h0000;
      cnt_r  <= 2'd0;
    end else begin
      pend_r <= pend_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

@@ sv/b64enc_queue.sv @@
// ----------------------------------------------------------------------------
// b64enc_queue
// short group queue between front and back
// ----------------------------------------------------------------------------
module b64enc_queue #(
  parameter int QDEPTH = 2
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  b64enc_pkg::grp_push_t push,
  output logic                  q_ready,
  output b64enc_pkg::grp_head_t head,
  input  logic                  pop
);

  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CW = $clog2(QDEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(QDEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(QDEPTH);

  b64enc_pkg::grp_entry_t mem_r [QDEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign q_ready    = (count_r != FULL_CNT);
  assign head.valid = (count_r != '0);
  assign head.entry = mem_r[rd_ptr_r];
  assign do_push    = push.valid && q_ready;
  assign do_pop     = pop && head.valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PW'(1);
    end
    case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + CW'(1);
      2'b01:   count_nxt = count_r - CW'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push.entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

@@ sv/b64enc_back.sv @@
// ----------------------------------------------------------------------------
// b64enc_back
// serializes each group into four characters through an output register
// ----------------------------------------------------------------------------
module b64enc_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  b64enc_pkg::grp_head_t head,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            out_char,
  output logic                  out_run_end,
  output logic                  out_message_end
);

  b64enc_pkg::grp_entry_t cur_r, cur_nxt;
  logic       busy_r, busy_nxt;
  logic [1:0] k_r, k_nxt;
  logic       ov_r, ov_nxt;
  logic [7:0] ch_r, ch_nxt;
  logic       re_r, re_nxt;
  logic       me_r, me_nxt;
  logic       load;

  assign load = !ov_r || out_ready;

  always_comb begin
    cur_nxt  = cur_r;
    busy_nxt = busy_r;
    k_nxt    = k_r;
    ov_nxt   = ov_r;
    ch_nxt   = ch_r;
    re_nxt   = re_r;
    me_nxt   = me_r;
    pop      = 1'b0;
    if (load) begin
      if (busy_r) begin
        ov_nxt   = 1'b1;
        ch_nxt   = b64enc_pkg::enc_char(cur_r.group, cur_r.nbytes, k_r);
        re_nxt   = (k_r == 2'd3);
        me_nxt   = (k_r == 2'd3) && cur_r.fin;
        k_nxt    = k_r + 2'd1;
        busy_nxt = (k_r != 2'd3);
      end else if (head.valid) begin
        pop      = 1'b1;
        cur_nxt  = head.entry;
        ov_nxt   = 1'b1;
        ch_nxt   = b64enc_pkg::enc_char(head.entry.group, head.entry.nbytes, 2'd0);
        re_nxt   = 1'b0;
        me_nxt   = 1'b0;
        k_nxt    = 2'd1;
        busy_nxt = 1'b1;
      end else begin
        ov_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      k_r    <= 2'd0;
      ov_r   <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      k_r    <= k_nxt;
      ov_r   <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    ch_r  <= ch_nxt;
    re_r  <= re_nxt;
    me_r  <= me_nxt;
  end

  assign out_valid       = ov_r;
  assign out_char        = ch_r;
  assign out_run_end     = re_r;
  assign out_message_end = me_r;

endmodule

@@ sv/base64_stream_encoder.sv @@
// ----------------------------------------------------------------------------
// base64_stream_encoder
// byte stream to base64 characters, standard alphabet with '=' padding
// ----------------------------------------------------------------------------
// in_bus takes one message byte per beat, final_byte set on the last byte of
// a message. out_bus gives one character per beat; run_end marks the fourth
// character of a group and message_end the last character of a message.
// every third byte, or a byte with final_byte set, closes a group of four
// characters; other bytes give no output.
// the first character of a group passes through the group queue, then the
// output register; the rest follow one per cycle while out_bus.ready is high.
// throughput: in_bus takes a byte every cycle while the group queue has room;
// sustained rate is set by the one-character output register, which gives
// four characters for every three bytes.
// a back-pressured out_bus holds its character; the group queue (QDEPTH
// groups) then fills and in_bus.ready drops until the back end drains it.
// reset clears the pending bytes, the queue and the output valid flag.
// ----------------------------------------------------------------------------
`include "base64_stream_encoder_assert.svh"

module base64_stream_encoder #(
  parameter int QDEPTH = 2
) (
  input  logic          clk,
  input  logic          rst_n,
  b64enc_in_if.sink     in_bus,
  b64enc_out_if.source  out_bus
);

  b64enc_pkg::grp_push_t push;
  b64enc_pkg::grp_head_t head;
  logic                  q_ready;
  logic                  pop;

  b64enc_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_bus.valid),
    .in_ready      (in_bus.ready),
    .in_data_byte  (in_bus.data_byte),
    .in_final_byte (in_bus.final_byte),
    .q_ready       (q_ready),
    .push          (push)
  );

  b64enc_queue #(
    .QDEPTH (QDEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .q_ready (q_ready),
    .head    (head),
    .pop     (pop)
  );

  b64enc_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head            (head),
    .pop             (pop),
    .out_valid       (out_bus.valid),
    .out_ready       (out_bus.ready),
    .out_char        (out_bus.out_char),
    .out_run_end     (out_bus.run_end),
    .out_message_end (out_bus.message_end)
  );

  `B64_ASSERT_NOW(a_msg_end_on_run_end, out_bus.valid && out_bus.message_end, out_bus.run_end)
  `B64_ASSERT_NOW(a_push_has_room, push.valid, q_ready)
  `B64_ASSERT_NEXT(a_pop_fills_output, pop, out_bus.valid && !out_bus.run_end)

endmodule
